@@ rtl/rpe_pkg.sv @@
// Shared types and codes for the relocation patch encoder.
package rpe_pkg;

  typedef enum logic [3:0] {
    KIND_UBYTE       = 4'd0,
    KIND_SBYTE       = 4'd1,
    KIND_HIGHOFF     = 4'd2,
    KIND_UBYTE2WORD  = 4'd3,
    KIND_SBYTE2WORD  = 4'd4,
    KIND_UBYTE2PTR24 = 4'd5,
    KIND_SBYTE2PTR24 = 4'd6,
    KIND_PTR24       = 4'd7,
    KIND_WORD        = 4'd8,
    KIND_WORDBE      = 4'd9,
    KIND_DWORD       = 4'd10,
    KIND_JR          = 4'd11,
    KIND_JRE         = 4'd12,
    KIND_ASSIGN      = 4'd13
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_WARN  = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  // Patch after the relative adjustment, as handed to the encoder.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [3:0]  size;
    logic [3:0]  offset;
  } adj_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0]      mask;
    status_t         status;
  } res_t;

endpackage

@@ rtl/relocation_patch_encoder_top.sv @@
// Relocation patch encoder: three-stage pipeline, one patch word per cycle when not stalled.
//
// Input channel (in_valid/in_ready) takes one patch word: kind, evaluated
// target value, instruction address and length, and patch offset. The result
// channel (out_valid/out_ready) gives one word per patch: four bytes, a write
// mask and a status (ok, range warning with bytes written, error with none).
// Stages: length cap and jump base add; relative subtract; range check and
// byte encoding into the output register. The accepted word moves through the
// stage 1 and stage 2 registers to the output register that drives out_valid;
// throughput is one word per cycle while out_ready is high, as no stage has a
// shared unit. The length is capped at MAX_INSTR_BYTES before use.
// Each stage holds its word while the next one is full, so a stall on
// out_ready backs up through the stages and then drops in_ready; nothing is
// lost or repeated. Synchronous active-low reset empties the pipeline;
// there is no other state.
module relocation_patch_encoder_top #(
  parameter int MAX_INSTR_BYTES = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic signed [31:0] in_target_value,
  input  logic [23:0] in_instr_address,
  input  logic [3:0]  in_instr_size,
  input  logic [3:0]  in_patch_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic [3:0]  out_write_mask,
  output logic [1:0]  out_patch_status
);

  logic          adj_valid;
  logic          adj_ready;
  rpe_pkg::adj_t adj_data;
  rpe_pkg::res_t res_data;

  rpe_adjust #(
    .MAX_INSTR_BYTES(MAX_INSTR_BYTES)
  ) u_adjust (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_target_value (in_target_value),
    .in_instr_address(in_instr_address),
    .in_instr_size   (in_instr_size),
    .in_patch_offset (in_patch_offset),
    .adj_valid       (adj_valid),
    .adj_ready       (adj_ready),
    .adj_data        (adj_data)
  );

  rpe_encode u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .adj_valid(adj_valid),
    .adj_ready(adj_ready),
    .adj_data (adj_data),
    .res_valid(out_valid),
    .res_ready(out_ready),
    .res_data (res_data)
  );

  assign out_byte0        = res_data.bytes[0];
  assign out_byte1        = res_data.bytes[1];
  assign out_byte2        = res_data.bytes[2];
  assign out_byte3        = res_data.bytes[3];
  assign out_write_mask   = res_data.mask;
  assign out_patch_status = res_data.status;

endmodule

@@ rtl/rpe_adjust.sv @@
// Length cap, jump base and relative subtract: two pipeline stages.
module rpe_adjust #(
  parameter int MAX_INSTR_BYTES = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_kind,
  input  logic [31:0]        in_target_value,
  input  logic [23:0]        in_instr_address,
  input  logic [3:0]         in_instr_size,
  input  logic [3:0]         in_patch_offset,
  output logic               adj_valid,
  input  logic               adj_ready,
  output rpe_pkg::adj_t      adj_data
);

  localparam logic [7:0] MaxBytes = MAX_INSTR_BYTES[7:0];

  // stage 1
  logic        s1_valid_r, s1_valid_nxt;
  logic [3:0]  s1_kind_r;
  logic [31:0] s1_tgt_r;
  logic [24:0] s1_base_r;
  logic [3:0]  s1_size_r;
  logic [3:0]  s1_off_r;
  logic        s1_ready;
  logic        s1_load;
  logic [3:0]  size_cap;

  // stage 2
  logic          s2_valid_r, s2_valid_nxt;
  rpe_pkg::adj_t s2_data_r, s2_data_nxt;
  logic          s2_ready;
  logic          s2_load;
  logic          is_rel;

  assign s2_ready = !s2_valid_r || adj_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = s1_valid_r && s2_ready;

  // cap only bites when the limit is below the field range
  assign size_cap = ({4'd0, in_instr_size} > MaxBytes) ? MaxBytes[3:0] : in_instr_size;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind_r <= in_kind;
      s1_tgt_r  <= in_target_value;
      s1_base_r <= {1'b0, in_instr_address} + {21'd0, size_cap};
      s1_size_r <= size_cap;
      s1_off_r  <= in_patch_offset;
    end
  end

  assign is_rel = (s1_kind_r == rpe_pkg::KIND_JR) || (s1_kind_r == rpe_pkg::KIND_JRE);

  always_comb begin
    s2_valid_nxt       = s2_valid_r;
    if (s2_ready) begin
      s2_valid_nxt = s1_valid_r;
    end
    s2_data_nxt.kind   = s1_kind_r;
    s2_data_nxt.value  = is_rel ? (s1_tgt_r - {7'd0, s1_base_r}) : s1_tgt_r;
    s2_data_nxt.size   = s1_size_r;
    s2_data_nxt.offset = s1_off_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign adj_valid = s2_valid_r;
  assign adj_data  = s2_data_r;

endmodule

@@ rtl/rpe_encode.sv @@
// Range check, byte encoding and write mask; the output register stage.
module rpe_encode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adj_valid,
  output logic          adj_ready,
  input  rpe_pkg::adj_t adj_data,
  output logic          res_valid,
  input  logic          res_ready,
  output rpe_pkg::res_t res_data
);

  logic          valid_r, valid_nxt;
  rpe_pkg::res_t res_r, res_nxt;
  logic          load;

  logic [31:0]     u;
  logic [3:0][7:0] b;
  logic [7:0]      ext;
  logic [2:0]      used;
  logic            fits_s8, fits_u8, fits_s16, fits_ubyte, high_ok;
  logic [4:0]      pos;
  logic            wr;

  assign adj_ready = !valid_r || res_ready;
  assign load      = adj_valid && adj_ready;

  assign u          = adj_data.value;
  assign fits_u8    = (u[31:8] == 24'd0);
  assign fits_s8    = (u[31:7] == 25'd0) || (&u[31:7]);
  assign fits_ubyte = fits_u8 || (&u[31:7]);
  assign fits_s16   = (u[31:15] == 17'd0) || (&u[31:15]);
  assign high_ok    = (u[15:8] == 8'h00) || (u[15:8] == 8'hff);
  assign ext        = (u[31:7] != 25'd0) ? 8'hff : 8'h00;

  always_comb begin
    b              = {u[31:24], u[23:16], u[15:8], u[7:0]};
    used           = 3'd0;
    res_nxt.status = rpe_pkg::STATUS_OK;
    res_nxt.mask   = 4'd0;
    res_nxt.bytes  = '0;
    pos            = 5'd0;
    wr             = 1'b0;
    unique case (rpe_pkg::kind_t'(adj_data.kind))
      rpe_pkg::KIND_UBYTE: begin
        if (!fits_ubyte) res_nxt.status = rpe_pkg::STATUS_WARN;
        used = 3'd1;
      end
      rpe_pkg::KIND_SBYTE: begin
        if (!fits_s8) res_nxt.status = rpe_pkg::STATUS_WARN;
        used = 3'd1;
      end
      rpe_pkg::KIND_HIGHOFF: begin
        if (!high_ok) res_nxt.status = rpe_pkg::STATUS_WARN;
        used = 3'd1;
      end
      rpe_pkg::KIND_UBYTE2WORD: begin
        if (!fits_u8) res_nxt.status = rpe_pkg::STATUS_WARN;
        b[1] = 8'h00;
        used = 3'd2;
      end
      rpe_pkg::KIND_SBYTE2WORD: begin
        if (!fits_s8) res_nxt.status = rpe_pkg::STATUS_WARN;
        b[1] = ext;
        used = 3'd2;
      end
      rpe_pkg::KIND_UBYTE2PTR24: begin
        if (!fits_u8) res_nxt.status = rpe_pkg::STATUS_WARN;
        b[1] = 8'h00;
        b[2] = 8'h00;
        used = 3'd3;
      end
      rpe_pkg::KIND_SBYTE2PTR24: begin
        if (!fits_s8) res_nxt.status = rpe_pkg::STATUS_WARN;
        b[1] = ext;
        b[2] = ext;
        used = 3'd3;
      end
      rpe_pkg::KIND_PTR24:  used = 3'd3;
      rpe_pkg::KIND_WORD:   used = 3'd2;
      rpe_pkg::KIND_WORDBE: begin
        b[0] = u[15:8];
        b[1] = u[7:0];
        used = 3'd2;
      end
      rpe_pkg::KIND_DWORD:  used = 3'd4;
      rpe_pkg::KIND_JR: begin
        if (!fits_s8) res_nxt.status = rpe_pkg::STATUS_ERROR;
        else used = 3'd1;
      end
      rpe_pkg::KIND_JRE: begin
        if (!fits_s16) res_nxt.status = rpe_pkg::STATUS_ERROR;
        else used = 3'd2;
      end
      rpe_pkg::KIND_ASSIGN: used = 3'd0;
      default: begin
        // undefined kind codes
        res_nxt.status = rpe_pkg::STATUS_ERROR;
        used           = 3'd0;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      pos = {1'b0, adj_data.offset} + 5'(i);
      wr  = (3'(i) < used) && (pos < {1'b0, adj_data.size});
      res_nxt.mask[i]  = wr;
      res_nxt.bytes[i] = wr ? b[i] : 8'h00;
    end
    valid_nxt = valid_r;
    if (adj_ready) begin
      valid_nxt = adj_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res_data  = res_r;

endmodule

@@ tb/relocation_patch_encoder_top_test.sv @@
// Self-checking bench for the relocation patch encoder: directed and random patches, random stalls.
`timescale 1ns / 100ps

module relocation_patch_encoder_top_test;

  localparam int MAX_INSTR_BYTES = 15;
  localparam int IDLE_LIMIT      = 3000;  // cycles with no word moving on either side
  localparam int LONG_HOLD       = 400;
  localparam int RANDOM_PATCHES  = 1930;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] target;
    logic [23:0] addr;
    logic [3:0]  size;
    logic [3:0]  offset;
    bit          drain;   // sender waits for all results before offering this one
  } patch_t;

  typedef struct {
    logic [3:0][7:0]  bytes;
    logic [3:0]       mask;
    rpe_pkg::status_t status;
  } encoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_kind = '0;
  logic [31:0] in_target_value = '0;
  logic [23:0] in_instr_address = '0;
  logic [3:0]  in_instr_size = '0;
  logic [3:0]  in_patch_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte0, out_byte1, out_byte2, out_byte3;
  logic [3:0]  out_write_mask;
  logic [1:0]  out_patch_status;

  patch_t   patch_q[$];
  encoded_t encoded_q[$];

  int  n_total, n_in, n_out, n_fail;
  int  n_ok, n_warn, n_err;
  int  tx_gap, rx_gap, hold_left;
  bit  long_hold_done, timed_out;
  bit  in_accepted = 1'b0;
  bit  [15:0] kinds_seen;

  relocation_patch_encoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_target_value  (in_target_value),
    .in_instr_address (in_instr_address),
    .in_instr_size    (in_instr_size),
    .in_patch_offset  (in_patch_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte0        (out_byte0),
    .out_byte1        (out_byte1),
    .out_byte2        (out_byte2),
    .out_byte3        (out_byte3),
    .out_write_mask   (out_write_mask),
    .out_patch_status (out_patch_status)
  );

  always #4 clk = ~clk;

  // Expected bytes, mask and status for one patch.
  function automatic encoded_t encode_patch(input patch_t p);
    encoded_t        r;
    logic [3:0]      len;
    logic [31:0]     val;
    logic signed [31:0] sval;
    logic [7:0]      ext;
    logic [3:0][7:0] b;
    int              span;
    len = (p.size > MAX_INSTR_BYTES) ? 4'(MAX_INSTR_BYTES) : p.size;
    val = p.target;
    if (p.kind == rpe_pkg::KIND_JR || p.kind == rpe_pkg::KIND_JRE)
      val = p.target - ({8'd0, p.addr} + {28'd0, len});
    sval = signed'(val);
    ext = (sval < 0 || sval > 127) ? 8'hff : 8'h00;
    b = val;
    span = 0;
    r.status = rpe_pkg::STATUS_OK;
    case (p.kind)
      rpe_pkg::KIND_UBYTE: begin
        if (sval < -128 || sval > 255) r.status = rpe_pkg::STATUS_WARN;
        span = 1;
      end
      rpe_pkg::KIND_SBYTE: begin
        if (sval < -128 || sval > 127) r.status = rpe_pkg::STATUS_WARN;
        span = 1;
      end
      rpe_pkg::KIND_HIGHOFF: begin
        if (val[15:8] != 8'h00 && val[15:8] != 8'hff) r.status = rpe_pkg::STATUS_WARN;
        span = 1;
      end
      rpe_pkg::KIND_UBYTE2WORD: begin
        if (sval < 0 || sval > 255) r.status = rpe_pkg::STATUS_WARN;
        b[1] = 8'h00;
        span = 2;
      end
      rpe_pkg::KIND_SBYTE2WORD: begin
        if (sval < -128 || sval > 127) r.status = rpe_pkg::STATUS_WARN;
        b[1] = ext;
        span = 2;
      end
      rpe_pkg::KIND_UBYTE2PTR24: begin
        if (sval < 0 || sval > 255) r.status = rpe_pkg::STATUS_WARN;
        b[1] = 8'h00;
        b[2] = 8'h00;
        span = 3;
      end
      rpe_pkg::KIND_SBYTE2PTR24: begin
        if (sval < -128 || sval > 127) r.status = rpe_pkg::STATUS_WARN;
        b[1] = ext;
        b[2] = ext;
        span = 3;
      end
      rpe_pkg::KIND_PTR24: span = 3;
      rpe_pkg::KIND_WORD:  span = 2;
      rpe_pkg::KIND_WORDBE: begin
        b[0] = val[15:8];
        b[1] = val[7:0];
        span = 2;
      end
      rpe_pkg::KIND_DWORD: span = 4;
      rpe_pkg::KIND_JR: begin
        if (sval < -128 || sval > 127) r.status = rpe_pkg::STATUS_ERROR;
        else span = 1;
      end
      rpe_pkg::KIND_JRE: begin
        if (sval < -32768 || sval > 32767) r.status = rpe_pkg::STATUS_ERROR;
        else span = 2;
      end
      rpe_pkg::KIND_ASSIGN: span = 0;
      default: r.status = rpe_pkg::STATUS_ERROR;  // unused kind codes
    endcase
    for (int i = 0; i < 4; i++) begin
      r.mask[i]  = (i < span) && (int'(p.offset) + i < int'(len));
      r.bytes[i] = r.mask[i] ? b[i] : 8'h00;
    end
    return r;
  endfunction

  task automatic queue_patch(input logic [3:0] kind, input logic [31:0] target,
                             input logic [23:0] addr, input logic [3:0] size,
                             input logic [3:0] offset, input bit drain);
    patch_t p;
    p.kind   = kind;
    p.target = target;
    p.addr   = addr;
    p.size   = size;
    p.offset = offset;
    p.drain  = drain;
    patch_q.insert(patch_q.size(), p);
  endtask

  function automatic patch_t random_patch();
    patch_t      p;
    logic [31:0] base;
    int          sel;
    p.drain = 1'b0;
    p.kind = ($urandom_range(0, 99) < 94) ? 4'($urandom_range(0, 13))
                                          : 4'($urandom_range(14, 15));
    p.addr = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 16'hffff));
    if ($urandom_range(0, 3) == 0) begin
      p.size   = 4'($urandom_range(0, 15));
      p.offset = 4'($urandom_range(0, 15));
    end else begin
      p.size   = 4'($urandom_range(1, 6));
      p.offset = 4'($urandom_range(0, 3));
    end
    base = {8'd0, p.addr} + {28'd0, p.size};
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: p.target = $urandom;
      3, 4, 5: p.target = int'($urandom_range(0, 640)) - 320;
      6: p.target = (($urandom_range(0, 1) != 0) ? 32767 : -32768)
                    + int'($urandom_range(0, 600)) - 300;
      7, 8: begin
        if (p.kind == rpe_pkg::KIND_JR || p.kind == rpe_pkg::KIND_JRE) begin
          if ($urandom_range(0, 1) != 0)
            p.target = base + 32'(int'($urandom_range(0, 280)) - 140);
          else
            p.target = base + 32'((($urandom_range(0, 1) != 0) ? 32767 : -32768)
                                  + int'($urandom_range(0, 6)) - 3);
        end else begin
          // high byte of the low word all zero, all one, or mixed
          p.target = $urandom;
          case ($urandom_range(0, 2))
            0: p.target[15:8] = 8'h00;
            1: p.target[15:8] = 8'hff;
            default: ;
          endcase
        end
      end
      default: begin
        case ($urandom_range(0, 3))
          0: p.target = 32'h8000_0000;
          1: p.target = 32'h7fff_ffff;
          2: p.target = 32'hffff_ffff;
          default: p.target = 32'h0000_0000;
        endcase
      end
    endcase
    return p;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in quiet phases.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    n_fail++;
    $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  // Sender: new word at the falling edge once the previous one has gone.
  always @(negedge clk) begin : sender
    patch_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // hold the word until taken
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (patch_q.size() > 0 && !(patch_q[0].drain && encoded_q.size() > 0)) begin
      p = patch_q.pop_front();
      in_kind          <= p.kind;
      in_target_value  <= p.target;
      in_instr_address <= p.addr;
      in_instr_size    <= p.size;
      in_patch_offset  <= p.offset;
      in_valid         <= 1'b1;
      tx_gap = pick_gap((n_in / 160) % 3 == 2);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random back-pressure plus one long hold while words keep coming.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && n_in >= 500) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_gap = pick_gap((n_out / 230) % 3 == 1);
    end
  end

  always @(posedge clk) begin : monitor
    patch_t          cur;
    encoded_t        want;
    logic [3:0][7:0] got;
    in_accepted <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        cur.kind   = in_kind;
        cur.target = in_target_value;
        cur.addr   = in_instr_address;
        cur.size   = in_instr_size;
        cur.offset = in_patch_offset;
        cur.drain  = 1'b0;
        encoded_q.insert(encoded_q.size(), encode_patch(cur));
        kinds_seen[in_kind] = 1'b1;
        n_in++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (encoded_q.size() == 0) begin
          n_fail++;
          $display("%0t: result word with nothing outstanding: bytes %h %h %h %h", $time,
                   out_byte3, out_byte2, out_byte1, out_byte0);
        end else begin
          want = encoded_q.pop_front();
          got = {out_byte3, out_byte2, out_byte1, out_byte0};
          for (int i = 0; i < 4; i++)
            if (got[i] !== want.bytes[i])
              report($sformatf("out_byte%0d", i), want.bytes[i], got[i]);
          if (out_write_mask !== want.mask)
            report("out_write_mask", want.mask, out_write_mask);
          if (out_patch_status !== want.status)
            report("out_patch_status", want.status, out_patch_status);
          case (want.status)
            rpe_pkg::STATUS_OK:   n_ok++;
            rpe_pkg::STATUS_WARN: n_warn++;
            default:              n_err++;
          endcase
        end
      end
    end
  end

  initial begin
    int idle;
    patch_t p;

    // directed: every kind, range edges of the checked kinds, unused codes, length and offset corners
    queue_patch(rpe_pkg::KIND_UBYTE,       32'd255,       24'h000000, 4'd2,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_UBYTE,       -32'sd129,     24'h000010, 4'd2,  4'd0, 1'b0);
    queue_patch(rpe_pkg::KIND_SBYTE,       -32'sd128,     24'h000020, 4'd2,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_SBYTE,       32'd128,       24'h000030, 4'd2,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_HIGHOFF,     32'h0000_1234, 24'h000040, 4'd2,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_HIGHOFF,     32'hffff_ff80, 24'h000040, 4'd2,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_UBYTE2WORD,  32'd256,       24'h000050, 4'd3,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_SBYTE2WORD,  32'hffff_ffff, 24'h000060, 4'd3,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_UBYTE2PTR24, 32'hffff_ffff, 24'h000070, 4'd4,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_SBYTE2PTR24, 32'd127,       24'h000080, 4'd4,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_PTR24,       32'h00ab_cdef, 24'h000090, 4'd4,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_WORD,        32'h8000_0000, 24'h0000a0, 4'd3,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_WORDBE,      32'h0000_1234, 24'h0000b0, 4'd3,  4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_DWORD,       32'h7fff_ffff, 24'h0000c0, 4'd15, 4'd11, 1'b0);
    queue_patch(rpe_pkg::KIND_JR, 32'h0000_0102 + 32'd127, 24'h000100, 4'd2, 4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_JR, 32'h0000_0102 + 32'd128, 24'h000100, 4'd2, 4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_JR, 32'h0000_0102 - 32'd128, 24'h000100, 4'd2, 4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_JRE, 32'h0100_000e - 32'd32768, 24'hffffff, 4'd15, 4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_JRE, 32'h0100_000e + 32'd32768, 24'hffffff, 4'd15, 4'd1, 1'b0);
    queue_patch(rpe_pkg::KIND_ASSIGN,      32'h1234_5678, 24'h000200, 4'd4,  4'd0, 1'b0);
    queue_patch(4'd14,                     32'h0000_0001, 24'h000210, 4'd4,  4'd0, 1'b0);
    queue_patch(4'd15,                     32'h0000_0001, 24'h000220, 4'd4,  4'd0, 1'b0);
    queue_patch(rpe_pkg::KIND_DWORD,       32'h1122_3344, 24'h000230, 4'd0,  4'd0, 1'b0);
    queue_patch(rpe_pkg::KIND_DWORD,       32'h1122_3344, 24'h000240, 4'd3,  4'd5, 1'b0);
    queue_patch(rpe_pkg::KIND_UBYTE,       32'd7,         24'h000250, 4'd15, 4'd15, 1'b0);

    for (int i = 0; i < RANDOM_PATCHES; i++) begin
      p = random_patch();
      p.drain = (i == 700 || i == 1400);
      patch_q.insert(patch_q.size(), p);
    end
    n_total = patch_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    fork
      begin
        while (!(n_in == n_total && encoded_q.size() == 0)) @(negedge clk);
        repeat (10) @(posedge clk);
      end
      begin
        idle = 0;
        while (idle < IDLE_LIMIT) begin
          @(posedge clk);
          if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
          else idle++;
        end
        timed_out = 1'b1;
      end
    join_any

    $display("patches in %0d, results out %0d: %0d ok, %0d range warnings, %0d errors",
             n_in, n_out, n_ok, n_warn, n_err);
    $display("kind codes seen %0d of 16, %0d field mismatches", $countones(kinds_seen), n_fail);
    if (timed_out) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
               IDLE_LIMIT, encoded_q.size());
      $display("relocation_patch_encoder_top_test: done, errors");
    end else if (n_fail == 0) begin
      $display("relocation_patch_encoder_top_test: done, clean");
    end else begin
      $display("relocation_patch_encoder_top_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rpe_pkg.sv
rtl/rpe_adjust.sv
rtl/rpe_encode.sv
rtl/relocation_patch_encoder_top.sv
tb/relocation_patch_encoder_top_test.sv
